[rtl/core/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Request kinds, status codes and controller/datapath handshake types
// shared by the bounded deque modules.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
    localparam logic [1:0] KIND_PUSH_REAR  = 2'd1;
    localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
    localparam logic [1:0] KIND_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic signed [31:0] POPPED_REFUSED = -32'sd1;
    localparam logic signed [31:0] POPPED_PUSH    = 32'sd0;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // request taken this cycle
        logic load_mem;  // move slot read data into the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_pop;
        logic full;
        logic empty;
    } t_sts;

endpackage

[rtl/core/bounded_deque.sv]
// ----------------------------------------------------------------------------
// bounded_deque
// Bounded double-ended queue of signed 32-bit words held in a circular
// buffer; push or pop at either end, one result per request.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------
//   request  | i_valid / o_stall  | i_kind, i_value
//   result   | o_valid / i_stall  | o_popped, o_status, o_occupancy
//
// Pushes and refused requests load their result when accepted; a pop with data
// first waits in S_READ for the registered read port of the slot memory.
// Reset is synchronous; it empties the queue, slot contents are kept.
// A new request is taken while a result waits, as long as the result
// register drains in the same cycle.
// ----------------------------------------------------------------------------
module bounded_deque #(
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_kind,
    input  logic signed [31:0]          i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [31:0]          o_popped,
    output logic [1:0]                  o_status,
    output logic [$clog2(DEPTH+1)-1:0]  o_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    bdq_pkg::t_cmd cmd;
    bdq_pkg::t_sts sts;

    bdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_sts       (sts),
        .o_popped    (o_popped),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_occupancy <= CW'(DEPTH)))
        else $error("occupancy above depth");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == bdq_pkg::ST_EMPTY)) |->
        ((o_popped == bdq_pkg::POPPED_REFUSED) && (o_occupancy == '0)))
        else $error("refused pop with wrong payload");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == bdq_pkg::ST_FULL)) |->
        ((o_popped == bdq_pkg::POPPED_PUSH) && (o_occupancy == CW'(DEPTH))))
        else $error("refused push with wrong payload");

endmodule

[rtl/core/bdq_ctrl.sv]
// ----------------------------------------------------------------------------
// bdq_ctrl
// Request sequencer: takes requests, waits out the slot read of a pop and
// keeps the result register's valid flag.
// ----------------------------------------------------------------------------
module bdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  bdq_pkg::t_sts i_sts,
    output bdq_pkg::t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;
    logic accept;
    logic load_mem;
    logic to_read;

    assign out_free = !r_out_valid || !i_stall;
    assign accept   = (r_state == S_IDLE) && i_valid && out_free;
    assign load_mem = (r_state == S_READ) && out_free;
    assign to_read  = accept && i_sts.is_pop && !i_sts.empty;

    assign o_stall        = !((r_state == S_IDLE) && out_free);
    assign o_valid        = r_out_valid;
    assign o_cmd.accept   = accept;
    assign o_cmd.load_mem = load_mem;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (to_read) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (load_mem) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (accept) begin
            // a pop with data waits in S_READ for the registered slot read
            n_out_valid = !to_read;
        end else if (load_mem) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/core/bdq_dpath.sv]
// ----------------------------------------------------------------------------
// bdq_dpath
// Circular slot buffer with head and fill count, index arithmetic and the
// result register.
// ----------------------------------------------------------------------------
module bdq_dpath #(
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bdq_pkg::t_cmd                    i_cmd,
    input  logic [1:0]                       i_kind,
    input  logic signed [31:0]               i_value,
    output bdq_pkg::t_sts                    o_sts,
    output logic signed [31:0]               o_popped,
    output logic [1:0]                       o_status,
    output logic [$clog2(DEPTH+1)-1:0]       o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic signed [31:0] r_popped, n_popped;
    logic [1:0]         r_status, n_status;
    logic [CW-1:0]      r_occ;

    logic          full, empty, is_pop;
    logic [AW-1:0] head_dec, head_inc;
    logic [SW-1:0] sum, sum_m1;
    logic [AW-1:0] tail, last;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;

    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);
    assign is_pop = (i_kind == bdq_pkg::KIND_POP_FRONT) ||
                    (i_kind == bdq_pkg::KIND_POP_REAR);

    assign o_sts.is_pop = is_pop;
    assign o_sts.full   = full;
    assign o_sts.empty  = empty;

    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    // head + count stays below twice the depth: one subtract wraps it
    assign sum    = SW'(r_head) + SW'(r_count);
    assign sum_m1 = sum - 1'b1;
    assign tail   = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);
    assign last   = (sum_m1 >= SW'(DEPTH)) ? AW'(sum_m1 - SW'(DEPTH)) : AW'(sum_m1);

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        wr_en    = 1'b0;
        wr_addr  = tail;
        rd_addr  = r_head;
        n_status = bdq_pkg::ST_OK;
        n_popped = is_pop ? bdq_pkg::POPPED_REFUSED : bdq_pkg::POPPED_PUSH;
        case (i_kind)
            bdq_pkg::KIND_PUSH_FRONT: begin
                if (full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = head_dec;
                    n_head  = head_dec;
                    n_count = r_count + 1'b1;
                end
            end
            bdq_pkg::KIND_PUSH_REAR: begin
                if (full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = tail;
                    n_count = r_count + 1'b1;
                end
            end
            bdq_pkg::KIND_POP_FRONT: begin
                if (empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    rd_addr = r_head;
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                end
            end
            bdq_pkg::KIND_POP_REAR: begin
                if (empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    rd_addr = last;
                    n_count = r_count - 1'b1;
                end
            end
            default: n_status = bdq_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // slot storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && wr_en) begin
            r_mem[wr_addr] <= i_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_status <= n_status;
            r_occ    <= n_count;
            r_popped <= n_popped;
        end else if (i_cmd.load_mem) begin
            r_popped <= r_rd_data;
        end
    end

    assign o_popped    = r_popped;
    assign o_status    = r_status;
    assign o_occupancy = r_occ;

endmodule

[tb/bounded_deque_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_tb
// Self-checking testbench for the bounded deque. A queue of requests feeds
// a clocked driver; a clocked monitor runs every accepted request through a
// local deque model and compares each result transfer, field by field,
// with the oldest expected result. Both sides idle in random bursts, and
// the receiver holds off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module bounded_deque_tb;

    localparam int DEPTH            = 16;
    localparam int OCC_W            = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS     = 650;
    localparam int TAIL_ITEMS       = 50;     // no idling for the last requests
    localparam int LONG_HOLD_AT     = 200;    // requests accepted before the long hold
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES     = 10;
    localparam int TIMEOUT_NS       = 2_000_000;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } t_deque_req;

    typedef struct packed {
        logic signed [31:0] popped;
        logic [1:0]         status;
        logic [OCC_W-1:0]   occupancy;
    } t_deque_rsp;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic [1:0]               i_kind      = bdq_pkg::KIND_PUSH_FRONT;
    logic signed [31:0]       i_value     = '0;
    logic                     i_stall     = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic signed [31:0]       o_popped;
    logic [1:0]               o_status;
    logic [OCC_W-1:0]         o_occupancy;

    t_deque_req request_queue[$];
    t_deque_rsp expected_results[$];

    // local copy of the deque contents
    logic signed [31:0] model_slots [DEPTH];
    int unsigned        model_head  = 0;
    int unsigned        model_count = 0;

    logic req_fire       = 1'b0;
    int   n_requests     = 0;
    int   n_checked      = 0;
    int   n_pushes       = 0;
    int   n_pops         = 0;
    int   n_refused_full = 0;
    int   n_refused_empty = 0;
    int   n_fail         = 0;

    bounded_deque #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_popped    (o_popped),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_deque_rsp deque_apply(input t_deque_req req);
        t_deque_rsp  rsp;
        int unsigned pos;
        rsp.popped = bdq_pkg::POPPED_PUSH;
        rsp.status = bdq_pkg::ST_OK;
        if (req.kind == bdq_pkg::KIND_PUSH_FRONT || req.kind == bdq_pkg::KIND_PUSH_REAR) begin
            if (model_count == DEPTH) begin
                rsp.status = bdq_pkg::ST_FULL;
                n_refused_full++;
            end else begin
                if (req.kind == bdq_pkg::KIND_PUSH_FRONT) begin
                    model_head = (model_head + DEPTH - 1) % DEPTH;
                    pos = model_head;
                end else begin
                    pos = (model_head + model_count) % DEPTH;
                end
                model_slots[pos] = req.value;
                model_count++;
                n_pushes++;
            end
        end else begin
            if (model_count == 0) begin
                rsp.status = bdq_pkg::ST_EMPTY;
                rsp.popped = bdq_pkg::POPPED_REFUSED;
                n_refused_empty++;
            end else begin
                if (req.kind == bdq_pkg::KIND_POP_FRONT) begin
                    pos = model_head;
                    model_head = (model_head + 1) % DEPTH;
                end else begin
                    pos = (model_head + model_count - 1) % DEPTH;
                end
                rsp.popped = model_slots[pos];
                model_count--;
                n_pops++;
            end
        end
        rsp.occupancy = OCC_W'(model_count);
        return rsp;
    endfunction

    // request driver: hold a stalled transfer, otherwise idle or advance
    int send_gap = 0;

    always @(negedge i_clk) begin
        t_deque_req req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !req_fire) begin
            // hold: payload stays put until the transfer happens
        end else if (send_gap > 0) begin
            send_gap--;
            i_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
            if (request_queue.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 17);
                i_valid <= 1'b0;
            end else begin
                req = request_queue.pop_front();
                i_valid <= 1'b1;
                i_kind  <= req.kind;
                i_value <= req.value;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // result receiver: random stall bursts plus one long hold
    int  sink_hold      = 0;
    bit  long_hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            i_stall <= 1'b1;
        end else if (!long_hold_done && n_requests >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            sink_hold = LONG_HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (request_queue.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
            sink_hold = $urandom_range(0, 17);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor: check the result transfer first, it can never belong to the
    // request taken at the same edge
    always @(posedge i_clk) begin : monitor
        t_deque_rsp want;
        t_deque_req req;
        if (!i_rst_n) begin
            req_fire <= 1'b0;
        end else begin
            if (o_valid === 1'b1 && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no request pending: popped %0d status %0d",
                           o_popped, o_status);
                    n_fail++;
                end else begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (o_popped !== want.popped) begin
                        $error("popped mismatch: expected %0d, actual %0d",
                               want.popped, o_popped);
                        n_fail++;
                    end
                    if (o_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, o_status);
                        n_fail++;
                    end
                    if (o_occupancy !== want.occupancy) begin
                        $error("occupancy mismatch: expected %0d, actual %0d",
                               want.occupancy, o_occupancy);
                        n_fail++;
                    end
                end
            end
            req_fire <= i_valid && (o_stall === 1'b0);
            if (i_valid && o_stall === 1'b0) begin
                req.kind  = i_kind;
                req.value = i_value;
                expected_results.push_back(deque_apply(req));
                n_requests++;
            end
        end
    end

    initial begin : stimulus
        t_deque_req         req;
        logic signed [31:0] corner [8];
        int                 built;
        int                 seg_len;
        int                 push_pct;
        corner = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1,
                   32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_F0F0};

        // directed: pops on empty, fill to full from both ends with
        // corner words, refused pushes, then pops from both ends
        request_queue.push_back('{bdq_pkg::KIND_POP_FRONT, $urandom()});
        request_queue.push_back('{bdq_pkg::KIND_POP_REAR, $urandom()});
        for (int k = 0; k < DEPTH; k++) begin
            req.kind  = (k % 2 == 0) ? bdq_pkg::KIND_PUSH_FRONT : bdq_pkg::KIND_PUSH_REAR;
            req.value = (k < 8) ? corner[k] : $urandom();
            request_queue.push_back(req);
        end
        request_queue.push_back('{bdq_pkg::KIND_PUSH_FRONT, $urandom()});
        request_queue.push_back('{bdq_pkg::KIND_PUSH_REAR, $urandom()});
        request_queue.push_back('{bdq_pkg::KIND_POP_FRONT, $urandom()});
        request_queue.push_back('{bdq_pkg::KIND_POP_REAR, $urandom()});
        request_queue.push_back('{bdq_pkg::KIND_POP_REAR, $urandom()});
        request_queue.push_back('{bdq_pkg::KIND_POP_FRONT, $urandom()});

        // random: segments leaning toward fill, drain or balance so the
        // queue keeps hitting both full and empty
        built = 0;
        while (built < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       push_pct = 80;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            seg_len = $urandom_range(8, 40);
            for (int k = 0; k < seg_len && built < RANDOM_ITEMS; k++) begin
                if ($urandom_range(0, 99) < push_pct) begin
                    req.kind = $urandom_range(0, 1) ? bdq_pkg::KIND_PUSH_REAR
                                                    : bdq_pkg::KIND_PUSH_FRONT;
                end else begin
                    req.kind = $urandom_range(0, 1) ? bdq_pkg::KIND_POP_REAR
                                                    : bdq_pkg::KIND_POP_FRONT;
                end
                case ($urandom_range(0, 9))
                    0:       req.value = 32'sh7FFF_FFFF;
                    1:       req.value = 32'sh8000_0000;
                    2:       req.value = 32'sh0;
                    3:       req.value = -32'sd1;
                    default: req.value = $urandom();
                endcase
                request_queue.push_back(req);
                built++;
            end
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests, %0d results checked", n_requests, n_checked);
        $display("  pushes %0d, pops %0d, refused on full %0d, refused on empty %0d",
                 n_pushes, n_pops, n_refused_full, n_refused_empty);
        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $error("timeout with %0d requests queued and %0d results outstanding",
               request_queue.size(), expected_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[bounded_deque.f]
rtl/core/bdq_pkg.sv
rtl/core/bdq_ctrl.sv
rtl/core/bdq_dpath.sv
rtl/core/bounded_deque.sv
tb/bounded_deque_tb.sv
